// ===== rtl/pid_with_time_proportioning_unit_assert.svh =====
// ---------------------------------------------------------------------------
// assertion macros for the pid unit
// ---------------------------------------------------------------------------
`ifndef PID_WITH_TIME_PROPORTIONING_UNIT_ASSERT_SVH
`define PID_WITH_TIME_PROPORTIONING_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PID_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("label failed");
`define PID_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("label failed");
`else
`define PID_ASSERT_IMP(label, ante, cons)
`define PID_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== rtl/pidtp_pkg.sv =====
// ---------------------------------------------------------------------------
// pidtp_pkg
// shared types, constants and helpers of the pid unit
// ---------------------------------------------------------------------------
package pidtp_pkg;
  localparam int SW = 24;
  localparam int GW = 32;
  localparam int AW = 48;
  localparam int EW = SW + 1;
  localparam int TW = 62;
  localparam int DVW = 16;

  localparam logic [1:0] MODE_MANUAL  = 2'd0;
  localparam logic [1:0] MODE_ANALOG  = 2'd1;
  localparam logic [1:0] MODE_DIGITAL = 2'd2;

  localparam logic [2:0] REG_MODE  = 3'd0;
  localparam logic [2:0] REG_GAINP = 3'd1;
  localparam logic [2:0] REG_GAINI = 3'd2;
  localparam logic [2:0] REG_GAIND = 3'd3;
  localparam logic [2:0] REG_OUTLO = 3'd4;
  localparam logic [2:0] REG_OUTHI = 3'd5;

  typedef struct packed {
    logic signed [SW-1:0] target;
    logic signed [SW-1:0] measured;
    logic [15:0] elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic signed [SW-1:0] drive;
    logic switch_on;
    logic switch_changed;
    logic output_written;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_ERR, OP_DIV, OP_MUL_P, OP_MUL_I, OP_MUL_D, OP_FINISH
  } op_t;

  typedef struct packed {
    op_t op;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic busy;
  } stat_t;

  function automatic logic [15:0] window_of(input logic signed [SW-1:0] h);
    if (h <= 0) return 16'd0;
    if ((h >>> 8) > 65535) return 16'hffff;
    return 16'((h >>> 8));
  endfunction
endpackage

// ===== rtl/pid_with_time_proportioning_unit.sv =====
// ---------------------------------------------------------------------------
// pid_with_time_proportioning_unit
// pid controller with clamped drive and time-proportioned switch output
// ---------------------------------------------------------------------------
// A tick in analog or digital mode runs from accept to result valid in these
// steps: the input beat is captured at accept, then a 26-step shift-subtract
// divider for the derivative, then three 48-step shift-add products for the
// p, i and d terms on one serial multiplier. A manual-mode tick returns the
// held drive in the cycle after accept. The next tick is accepted once the
// previous result beat has been taken.
module pid_with_time_proportioning_unit (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  pidtp_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output pidtp_pkg::out_item_t out_data,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data
);
  import pidtp_pkg::*;

  logic [1:0] mode;
  logic signed [GW-1:0] gain_p, gain_i, gain_d;
  logic signed [SW-1:0] output_low, output_high;
  cmd_t cmd;
  stat_t stat;
  logic win_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_ANALOG;
      gain_p <= GW'(65536);
      gain_i <= '0;
      gain_d <= '0;
      output_low <= '0;
      output_high <= SW'(25600);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:  mode <= cfg_data[1:0];
        REG_GAINP: gain_p <= cfg_data[GW-1:0];
        REG_GAINI: gain_i <= cfg_data[GW-1:0];
        REG_GAIND: gain_d <= cfg_data[GW-1:0];
        REG_OUTLO: output_low <= cfg_data[SW-1:0];
        REG_OUTHI: output_high <= cfg_data[SW-1:0];
        default: ;
      endcase
    end
  end

  assign win_load = cfg_we && (cfg_index == REG_OUTHI);

  pidtp_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
    .mode, .stat, .cmd
  );

  pidtp_datapath u_dp (
    .clk, .rst, .cmd, .stat, .in_item(in_data), .mode,
    .gain_p, .gain_i, .gain_d, .output_low, .output_high,
    .win_load, .win_value(window_of(cfg_data[SW-1:0])),
    .result(out_data)
  );
endmodule

// ===== rtl/pidtp_datapath.sv =====
// ---------------------------------------------------------------------------
// pidtp_datapath
// error, integral, serial divider, serial multiplier and window logic
// ---------------------------------------------------------------------------
module pidtp_datapath (
  input  logic clk,
  input  logic rst,
  input  pidtp_pkg::cmd_t cmd,
  output pidtp_pkg::stat_t stat,
  input  pidtp_pkg::in_item_t in_item,
  input  logic [1:0] mode,
  input  logic signed [pidtp_pkg::GW-1:0] gain_p,
  input  logic signed [pidtp_pkg::GW-1:0] gain_i,
  input  logic signed [pidtp_pkg::GW-1:0] gain_d,
  input  logic signed [pidtp_pkg::SW-1:0] output_low,
  input  logic signed [pidtp_pkg::SW-1:0] output_high,
  input  logic win_load,
  input  logic [15:0] win_value,
  output pidtp_pkg::out_item_t result
);
  import pidtp_pkg::*;

  logic signed [EW-1:0] err, prev_err;
  logic signed [AW-1:0] integ;
  logic [15:0] dt;
  logic signed [SW-1:0] held;
  logic [15:0] wcount, wlen;
  logic prev_sw;

  // serial divider state
  logic [EW:0] dnum;
  logic [EW:0] drem;
  logic dneg;
  logic [5:0] dcnt;
  logic signed [EW+1:0] dquot;

  // serial multiplier state (radix 2, magnitude)
  logic [AW-1:0] mb;
  logic [GW-1:0] ma;
  logic [AW+GW-1:0] macc;
  logic mneg;
  logic [6:0] mcnt;
  logic signed [TW+2:0] dsum;

  logic signed [AW:0] inc_w, sum_w;
  logic signed [AW:0] acc_hi, acc_lo;
  logic signed [EW+1:0] diff;
  logic [EW:0] dmag;
  logic [EW+1:0] rtry;
  logic [AW+GW-1:0] shifted;
  logic [TW-1:0] tmag;
  logic signed [TW+2:0] term, dcl;
  logic swv;

  always_comb begin
    acc_hi = (AW+1)'({1'b0, {(AW-1){1'b1}}});
    acc_lo = -acc_hi - 1;
    inc_w = (AW+1)'(err) * $signed({1'b0, dt});
    sum_w = integ + inc_w;
    if (sum_w > acc_hi) sum_w = acc_hi;
    else if (sum_w < acc_lo) sum_w = acc_lo;
    diff = (EW+2)'(err) - (EW+2)'(prev_err);
    dmag = diff[EW+1] ? (EW+1)'(-diff) : (EW+1)'(diff);
    rtry = {drem, dnum[EW]} - {(EW-15)'(0), dt};
    shifted = macc >> 16;
    tmag = (shifted > (AW+GW)'(64'h1000000000000000)) ? TW'(64'h1000000000000000)
                                                      : TW'(shifted);
    term = mneg ? -(TW+3)'(tmag) : (TW+3)'(tmag);
    if (dsum > (TW+3)'(output_high)) dcl = (TW+3)'(output_high);
    else if (dsum < (TW+3)'(output_low)) dcl = (TW+3)'(output_low);
    else dcl = dsum;
    swv = ($signed((TW+3)'({wcount, 8'd0})) <= dcl);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integ <= '0;
      prev_err <= '0;
      held <= '0;
      wcount <= 16'd1;
      wlen <= 16'd0;
      prev_sw <= 1'b0;
      dcnt <= '0;
      mcnt <= '0;
      result <= '0;
    end else begin
      if (win_load) wlen <= win_value;
      if (dcnt != 0) begin
        dcnt <= dcnt - 1'b1;
        dnum <= dnum << 1;
        if (!rtry[EW+1]) begin
          drem <= rtry[EW:0];
          dquot <= {dquot[EW:0], 1'b1};
        end else begin
          drem <= {drem[EW-1:0], dnum[EW]};
          dquot <= dquot << 1;
        end
      end
      if (mcnt != 0) begin
        mcnt <= mcnt - 1'b1;
        if (mb[0]) macc <= macc + ((AW+GW)'(ma) << (AW - int'(mcnt)));
        mb <= mb >> 1;
      end
      unique case (cmd.op)
        OP_ERR: begin
          err <= (EW)'(in_item.target) - (EW)'(in_item.measured);
          dt <= in_item.elapsed_ms;
          dsum <= '0;
        end
        OP_DIV: begin
          integ <= AW'(sum_w);
          dneg <= diff[EW+1];
          dnum <= dmag;
          drem <= '0;
          dquot <= '0;
          dcnt <= 6'(EW + 1);
        end
        OP_MUL_P, OP_MUL_I, OP_MUL_D: begin
          logic signed [AW-1:0] x;
          logic signed [GW-1:0] g;
          if (cmd.op == OP_MUL_P) begin
            x = AW'(err); g = gain_p;
          end else if (cmd.op == OP_MUL_I) begin
            x = integ; g = gain_i;
          end else begin
            x = (dt == 0) ? '0 : (dneg ? -AW'(dquot) : AW'(dquot));
            g = gain_d;
          end
          if (mcnt == 0 && cmd.load) begin
            ma <= g[GW-1] ? GW'(-g) : GW'(g);
            mb <= x[AW-1] ? AW'(-x) : AW'(x);
            mneg <= g[GW-1] ^ x[AW-1];
            macc <= '0;
            mcnt <= 7'(AW);
          end else if (mcnt == 0 && !cmd.load) begin
            dsum <= dsum + term;
          end
        end
        OP_FINISH: begin
          prev_err <= err;
          held <= SW'(dcl);
          result.drive <= SW'(dcl);
          result.switch_on <= 1'b0;
          result.switch_changed <= 1'b0;
          result.output_written <= (mode == MODE_ANALOG) || (mode == MODE_DIGITAL);
          if (mode == MODE_DIGITAL) begin
            result.switch_on <= swv;
            result.switch_changed <= swv ^ prev_sw;
            prev_sw <= swv;
            if (17'(wcount) + 17'd1 > 17'(wlen)) begin
              wlen <= window_of(output_high);
              wcount <= 16'd1;
            end else begin
              wcount <= wcount + 16'd1;
            end
          end
        end
        OP_NONE: begin
          if (cmd.load) begin
            result.drive <= held;
            result.switch_on <= 1'b0;
            result.switch_changed <= 1'b0;
            result.output_written <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign stat.busy = (dcnt != 0) || (mcnt != 0);
endmodule

// ===== rtl/pidtp_ctrl.sv =====
// ---------------------------------------------------------------------------
// pidtp_ctrl
// sequencer for one tick and the output handshake
// ---------------------------------------------------------------------------
module pidtp_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  logic [1:0] mode,
  input  pidtp_pkg::stat_t stat,
  output pidtp_pkg::cmd_t cmd
);
  import pidtp_pkg::*;
  `include "pid_with_time_proportioning_unit_assert.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_DIVW, S_MP, S_MPW, S_MI, S_MIW, S_MD, S_MDW, S_FIN, S_OUT
  } state_t;
  state_t state;

  logic acc_in;
  assign in_ready = (state == S_IDLE) && !out_valid;
  assign acc_in = in_valid && in_ready;

  always_comb begin
    cmd = '{op: OP_NONE, load: 1'b0};
    unique case (state)
      S_IDLE: begin
        if (acc_in && (mode == MODE_MANUAL)) cmd = '{op: OP_NONE, load: 1'b1};
        else if (acc_in) cmd = '{op: OP_ERR, load: 1'b0};
      end
      S_DIV:  cmd = '{op: OP_DIV, load: 1'b1};
      S_MP:   cmd = '{op: OP_MUL_P, load: 1'b1};
      S_MPW:  cmd = '{op: OP_MUL_P, load: 1'b0};
      S_MI:   cmd = '{op: OP_MUL_I, load: 1'b1};
      S_MIW:  cmd = '{op: OP_MUL_I, load: 1'b0};
      S_MD:   cmd = '{op: OP_MUL_D, load: 1'b1};
      S_MDW:  cmd = '{op: OP_MUL_D, load: 1'b0};
      S_FIN:  cmd = '{op: OP_FINISH, load: 1'b0};
      default: cmd = '{op: OP_NONE, load: 1'b0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (acc_in) begin
          if (mode == MODE_MANUAL) out_valid <= 1'b1;
          else state <= S_DIV;
        end
        S_DIV: state <= S_DIVW;
        S_DIVW: if (!stat.busy) state <= S_MP;
        S_MP: state <= S_MPW;
        S_MPW: if (!stat.busy) state <= S_MI;
        S_MI: state <= S_MIW;
        S_MIW: if (!stat.busy) state <= S_MD;
        S_MD: state <= S_MDW;
        S_MDW: if (!stat.busy) state <= S_FIN;
        S_FIN: state <= S_OUT;
        S_OUT: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PID_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
  `PID_ASSERT_IMP(a_no_in_busy, out_valid, !in_ready)
  `PID_ASSERT_IMP(a_busy_state, stat.busy, state != S_IDLE)
endmodule
